### rtl/dvic_pkg.sv
// Package for double vs int64 compare: result codes and field constants.
`default_nettype none
package dvic_pkg;
    localparam logic [10:0] ExpMax = 11'h7FF;
    localparam logic signed [1:0] OrdLess = 2'sb11;
    localparam logic signed [1:0] OrdEq = 2'sb00;
    localparam logic signed [1:0] OrdGreater = 2'sb01;

    typedef struct packed {
        logic [63:0] double_bits;
        logic [63:0] int_value;
        logic        int_is_signed;
        logic        swap_order;
    } dvic_item_t;
endpackage
`default_nettype wire

### rtl/dvic_cmp.sv
// Combinational exact compare of a binary64 value with a 64-bit integer.
`default_nettype none
module dvic_cmp
    import dvic_pkg::*;
(
    input  var dvic_item_t       item,
    output logic signed [1:0]    order
);
    logic        dneg;
    logic [10:0] e;
    logic [51:0] f;
    logic        ineg;
    logic [63:0] imag;
    logic [52:0] mant;
    logic [115:0] wide;
    logic [63:0] ip;
    logic        frac;
    logic        big;
    logic signed [1:0] mag;
    logic signed [1:0] r;
    logic [11:0] sh;

    always_comb
    begin
        dneg = item.double_bits[63];
        e    = item.double_bits[62:52];
        f    = item.double_bits[51:0];
        ineg = item.int_is_signed & item.int_value[63];
        imag = ineg ? (~item.int_value + 64'd1) : item.int_value;
        mant = {(e != 11'd0), f};
        // value = mant * 2^(eff-1075); place binary point at bit 52 of wide
        sh   = (e == 11'd0) ? 12'd1 : {1'b0, e};
        big  = (sh >= 12'd1087);
        wide = (sh >= 12'd1023) ? ({63'd0, mant} << (sh - 12'd1023))
                                : ({63'd0, mant} >> (12'd1023 - sh));
        // wide holds value * 2^52 for shifts within range
        ip   = wide[115:52];
        frac = (sh >= 12'd1075) ? 1'b0
             : ((sh < 12'd1023) ? 1'b1 : (wide[51:0] != 52'd0));
        if (big)
            mag = OrdGreater;
        else if (ip != imag)
            mag = (ip > imag) ? OrdGreater : OrdLess;
        else
            mag = frac ? OrdGreater : OrdEq;

        if (e == ExpMax)
            r = (f != 52'd0 || dneg) ? OrdLess : OrdGreater;
        else if (e == 11'd0 && f == 52'd0)
            r = ineg ? OrdGreater : ((imag != 64'd0) ? OrdLess : OrdEq);
        else if (dneg != ineg)
            r = dneg ? OrdLess : OrdGreater;
        else
            r = dneg ? -mag : mag;
        order = item.swap_order ? -r : r;
    end
endmodule
`default_nettype wire

### rtl/double_vs_int64_compare_core.sv
// Top level: registered exact compare of a binary64 value with a 64-bit integer.
// The input is registered in item_reg and the dvic_cmp result in order_reg.
// Throughput: one transaction per cycle unless out_ready stalls the result; result
// and input registers advance together whenever the result stage is empty or taken.
// Reset: rst_n asynchronous active low clears both valid flags; no other state.
`default_nettype none
module double_vs_int64_compare_core
    import dvic_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [63:0]        double_bits,
    input  wire logic [63:0]        int_value,
    input  wire logic               int_is_signed,
    input  wire logic               swap_order,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [1:0]       order
);
    dvic_item_t        item_reg;
    logic              stg_valid_reg;
    logic              out_valid_reg;
    logic signed [1:0] order_reg;
    logic signed [1:0] order_next;
    logic              adv;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv || !stg_valid_reg;

    dvic_cmp u_cmp (.item(item_reg), .order(order_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
                out_valid_reg <= stg_valid_reg;
            if (in_ready)
                stg_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= '{double_bits, int_value, int_is_signed, swap_order};
        if (adv && stg_valid_reg)
            order_reg <= order_next;
    end

    assign out_valid = out_valid_reg;
    assign order     = order_reg;

    a_order_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (order != 2'sb10))
        else $error("illegal order code");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(order))
        else $error("result changed while stalled");
    a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
        stg_valid_reg && !adv |=> stg_valid_reg)
        else $error("staged transaction lost");
endmodule
`default_nettype wire

### test/tb_top.sv
// Testbench for double_vs_int64_compare_core: directed and random exact compares.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import dvic_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [63:0] double_bits = '0;
    logic [63:0] int_value = '0;
    logic int_is_signed = 1'b0;
    logic swap_order = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [1:0] order;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    logic signed [1:0] order_q[$];

    always #4 clk = ~clk;

    double_vs_int64_compare_core i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .double_bits(double_bits), .int_value(int_value),
        .int_is_signed(int_is_signed), .swap_order(swap_order),
        .out_valid(out_valid), .out_ready(out_ready), .order(order)
    );

    // magnitude compare of nonzero finite |double| against m
    function automatic int cmp_mag(logic [63:0] mant, int exp2, logic [63:0] m);
        logic [63:0] v;
        logic [63:0] ip;
        logic has_frac;
        int sh;
        if (exp2 >= 0)
        begin
            if (exp2 >= 12)
                return 1;
            v = mant << exp2;
            return (v > m) ? 1 : ((v < m) ? -1 : 0);
        end
        sh = -exp2;
        if (sh >= 64)
        begin
            ip = '0;
            has_frac = (mant != 0);
        end
        else
        begin
            ip = mant >> sh;
            has_frac = ((mant & ((64'd1 << sh) - 64'd1)) != 0);
        end
        if (ip != m)
            return (ip > m) ? 1 : -1;
        return has_frac ? 1 : 0;
    endfunction

    function automatic logic signed [1:0] predict_order(logic [63:0] d, logic [63:0] iv,
                                                       logic sgn, logic swp);
        logic dneg;
        logic [10:0] e;
        logic [51:0] f;
        logic ineg;
        logic [63:0] imag;
        logic [63:0] mant;
        int r;
        dneg = d[63];
        e = d[62:52];
        f = d[51:0];
        ineg = sgn && iv[63];
        imag = ineg ? (~iv + 64'd1) : iv;
        if (e == ExpMax)
            r = (f != 0) ? -1 : (dneg ? -1 : 1);
        else if (e == 0 && f == 0)
            r = ineg ? 1 : ((imag != 0) ? -1 : 0);
        else if (dneg != ineg)
            r = dneg ? -1 : 1;
        else
        begin
            mant = (e != 0) ? {12'd1, f} : {12'd0, f};
            r = cmp_mag(mant, ((e != 0) ? int'(e) : 1) - 1075, imag);
            if (dneg)
                r = -r;
        end
        if (swp)
            r = -r;
        return (r < 0) ? OrdLess : ((r > 0) ? OrdGreater : OrdEq);
    endfunction

    task automatic send_compare(logic [63:0] d, logic [63:0] iv, logic sgn, logic swp);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        double_bits <= d;
        int_value <= iv;
        int_is_signed <= sgn;
        swap_order <= swp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        order_q.push_back(predict_order(d, iv, sgn, swp));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (order_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver
    always @(posedge clk)
    begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
        if (rst_n && out_valid && out_ready)
        begin
            if (order_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: order=%0d", order);
            end
            else
            begin
                if (order !== order_q[0])
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("order mismatch: expected %0d got %0d", order_q[0], order);
                end
                void'(order_q.pop_front());
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // doubles near integer values of the given integer
    function automatic logic [63:0] near_double(logic [63:0] iv, logic sgn);
        logic neg;
        logic [63:0] mag;
        int msb;
        logic [63:0] d;
        neg = sgn && iv[63];
        mag = neg ? (~iv + 64'd1) : iv;
        if (mag == 0)
            return {neg, 63'd0};
        msb = 63;
        while (!mag[msb])
            msb--;
        if (msb >= 52)
            d = {neg, 11'(1023 + msb), 52'(mag >> (msb - 52))};
        else
            d = {neg, 11'(1023 + msb), 52'(mag << (52 - msb))};
        return d + 64'($urandom_range(4)) - 64'd2;
    endfunction

    task automatic test_directed();
        logic [63:0] dv[16];
        logic [63:0] iv[6];
        dv = '{64'h0, 64'h8000_0000_0000_0000, 64'h7FF0_0000_0000_0000,
               64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h0000_0000_0000_0001, 64'h800F_FFFF_FFFF_FFFF, 64'h3FF0_0000_0000_0000,
               64'hBFF0_0000_0000_0000, 64'h43E0_0000_0000_0000, 64'hC3E0_0000_0000_0000,
               64'h43F0_0000_0000_0000, 64'h4340_0000_0000_0001, 64'h3FF8_0000_0000_0000,
               64'h7FEF_FFFF_FFFF_FFFF};
        iv = '{64'h0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
               64'h7FFF_FFFF_FFFF_FFFF, 64'h0020_0000_0000_0001};
        foreach (dv[k])
            send_compare(dv[k], iv[k % 6], k[0], k[1]);
        foreach (iv[k])
            send_compare(near_double(iv[k], 1'b1), iv[k], 1'b1, k[0]);
    endtask

    task automatic test_random(int n);
        logic [63:0] d;
        logic [63:0] iv;
        logic sgn;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            iv = rand64();
            sgn = 1'($urandom_range(1));
            pick = $urandom_range(9);
            if (pick < 2)
                iv = iv >> $urandom_range(63);
            if (pick < 5)
                d = near_double(iv, sgn);
            else if (pick < 7)
                d = {$urandom_range(1) == 1, 11'($urandom_range(960, 1100)), 52'(rand64())};
            else if (pick == 7)
                d = {$urandom_range(1) == 1, $urandom_range(1) ? ExpMax : 11'd0,
                     52'(rand64())};
            else
                d = rand64();
            send_compare(d, iv, sgn, 1'($urandom_range(1)));
        end
    endtask

    task automatic test_phases();
        send_idle_pct = 82; recv_stall_pct = 0;
        test_random(300);
        send_idle_pct = 0; recv_stall_pct = 82;
        test_random(300);
        drain_results();
        send_idle_pct = 31; recv_stall_pct = 31;
        test_random(300);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(330);
        test_phases();
        drain_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

### sim.f
rtl/dvic_pkg.sv
rtl/dvic_cmp.sv
rtl/double_vs_int64_compare_core.sv
test/tb_top.sv
